// ===== src/pss_pkg.sv =====
// Package for the per-symbol price statistics unit.
// Shared types for the front/back queue; no dependencies.
package pss_pkg;

    typedef struct packed {
        logic        query;
        logic        in_range;
        logic [15:0] sym;
        logic [47:0] price;
        logic [31:0] volume;
    } cmd_t;

endpackage

// ===== src/pss_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module pss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== src/pss_front.sv =====
// Front end: accepts transactions, range-checks the symbol, queues commands.
// Depends on pss_pkg.
module pss_front #(
    parameter int SYMBOLS    = 1024,
    parameter int PRICE_BITS = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [73:0]     s_tdata,
    input  logic            s_tuser,
    output logic            q_valid,
    input  logic            q_ready,
    output pss_pkg::cmd_t   q_cmd
);
    // two-entry queue
    pss_pkg::cmd_t ent_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    pss_pkg::cmd_t cmd_in;
    logic push, pop;

    always_comb begin
        cmd_in.query    = s_tuser;
        cmd_in.sym      = {6'd0, s_tdata[9:0]};
        cmd_in.in_range = ({22'd0, s_tdata[9:0]} < 32'(SYMBOLS));
        cmd_in.price    = {16'd0, s_tdata[41:10]}
                        & ((48'd1 << PRICE_BITS) - 48'd1);
        cmd_in.volume   = s_tdata[73:42];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = ent_reg[rd_reg];
    assign push = s_tvalid && s_tready;
    assign pop  = q_valid && q_ready;

    always_comb begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
        rd_next  = rd_reg ^ pop;
        wr_next  = wr_reg ^ push;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) ent_reg[wr_reg] <= cmd_in;
    end
endmodule

// ===== src/pss_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// No dependencies.
module pss_div #(
    parameter int NW = 56,
    parameter int DW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] n_reg;
    logic          busy_reg;
    logic [DW:0]   trial;
    logic [DW:0]   shifted;

    assign shifted = {r_reg[DW-1:0], q_reg[NW-1]};
    assign trial   = shifted - {1'b0, d_reg};
    assign done    = busy_reg && (n_reg == CW'(0));
    assign quo     = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            n_reg    <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            n_reg    <= CW'(NW);
        end else if (done) begin
            busy_reg <= 1'b0;
        end else if (busy_reg) begin
            n_reg <= n_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end else if (busy_reg && n_reg != CW'(0)) begin
            if (!trial[DW]) begin
                r_reg <= trial;
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end else begin
                r_reg <= shifted;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end
endmodule

// ===== src/pss_back.sv =====
// Back end: reads the entry, updates statistics and writes back for in-range records, drives results.
// Depends on pss_pkg, pss_ram and pss_div.
module pss_back #(
    parameter int SYMBOLS    = 1024,
    parameter int PRICE_BITS = 32,
    parameter int FRAC_BITS  = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  pss_pkg::cmd_t   q_cmd,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [247:0]    m_tdata,
    output logic            m_tuser,
    output logic            busy
);
    localparam int AW = $clog2(SYMBOLS);
    localparam int MW = PRICE_BITS + FRAC_BITS;
    localparam int TW = $clog2(SYMBOLS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_CALC  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]     st_reg, st_next;
    logic [AW:0]    clr_reg;
    pss_pkg::cmd_t  cmd_reg;
    logic [TW-1:0]  trk_reg;
    logic           neg_reg;

    logic [31:0]         c_rd, c_new;
    logic [63:0]         v_rd, v_new;
    logic [PRICE_BITS-1:0] lo_rd, hi_rd, la_rd, lo_new, hi_new, pr;
    logic [MW-1:0]       mn_rd, mn_new, p_fx, diff;
    logic                we_c, we_d;
    logic [AW-1:0]       waddr, raddr;
    logic [31:0]         wc;

    logic                dv_start, dv_done;
    logic [MW-1:0]       dv_quo;

    // output register
    logic           o_val_reg;
    logic [247:0]   o_dat_reg, o_dat_next;
    logic           o_usr_reg, o_usr_next;

    assign pr     = cmd_reg.price[PRICE_BITS-1:0];
    assign p_fx   = MW'(pr) << FRAC_BITS;
    assign raddr  = cmd_reg.sym[AW-1:0];
    assign waddr  = (st_reg == ST_CLEAR) ? clr_reg[AW-1:0] : raddr;
    assign c_new  = (c_rd == 32'hFFFF_FFFF) ? c_rd : c_rd + 32'd1;
    assign lo_new = (c_rd == 32'd0 || pr < lo_rd) ? pr : lo_rd;
    assign hi_new = (c_rd == 32'd0 || pr > hi_rd) ? pr : hi_rd;
    assign v_new  = (c_rd == 32'd0) ? {32'd0, cmd_reg.volume} :
                    ((v_rd + {32'd0, cmd_reg.volume}) < v_rd) ? {64{1'b1}} :
                    v_rd + {32'd0, cmd_reg.volume};
    assign diff   = (p_fx >= mn_rd) ? p_fx - mn_rd : mn_rd - p_fx;
    assign mn_new = (c_rd == 32'd0) ? p_fx :
                    neg_reg ? mn_rd - dv_quo : mn_rd + dv_quo;
    assign wc     = (st_reg == ST_CLEAR) ? 32'd0 : c_new;
    assign we_c   = (st_reg == ST_CLEAR) ||
                    (st_reg == ST_DIV && (dv_done || c_rd == 32'd0));
    assign we_d   = (st_reg == ST_DIV && (dv_done || c_rd == 32'd0));
    assign dv_start = (st_reg == ST_CALC) && c_rd != 32'd0;

    pss_ram #(.WIDTH(32), .DEPTH(SYMBOLS)) u_cnt (
        .aclk, .we(we_c), .waddr, .wdata(wc), .raddr, .rdata(c_rd));
    pss_ram #(.WIDTH(64), .DEPTH(SYMBOLS)) u_vol (
        .aclk, .we(we_d), .waddr, .wdata(v_new), .raddr, .rdata(v_rd));
    pss_ram #(.WIDTH(PRICE_BITS), .DEPTH(SYMBOLS)) u_lo (
        .aclk, .we(we_d), .waddr, .wdata(lo_new), .raddr, .rdata(lo_rd));
    pss_ram #(.WIDTH(PRICE_BITS), .DEPTH(SYMBOLS)) u_hi (
        .aclk, .we(we_d), .waddr, .wdata(hi_new), .raddr, .rdata(hi_rd));
    pss_ram #(.WIDTH(PRICE_BITS), .DEPTH(SYMBOLS)) u_la (
        .aclk, .we(we_d), .waddr, .wdata(pr), .raddr, .rdata(la_rd));
    pss_ram #(.WIDTH(MW), .DEPTH(SYMBOLS)) u_mn (
        .aclk, .we(we_d), .waddr, .wdata(mn_new), .raddr, .rdata(mn_rd));

    pss_div #(.NW(MW), .DW(32)) u_div (
        .aclk, .aresetn, .start(dv_start), .num(diff), .den(c_new),
        .done(dv_done), .quo(dv_quo));

    assign q_ready  = (st_reg == ST_IDLE);
    assign m_tvalid = o_val_reg;
    assign m_tdata  = o_dat_reg;
    assign m_tuser  = o_usr_reg;
    assign busy     = (st_reg != ST_IDLE) || o_val_reg;

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_CLEAR: if (clr_reg == (AW+1)'(SYMBOLS - 1)) st_next = ST_IDLE;
            ST_IDLE:  if (q_valid) st_next = ST_READ;
            ST_READ:  st_next = (cmd_reg.in_range && !cmd_reg.query) ? ST_CALC : ST_OUT;
            ST_CALC:  st_next = ST_DIV;
            ST_DIV:   if (dv_done || c_rd == 32'd0) st_next = ST_READ;
            ST_OUT:   if (!o_val_reg || m_tready) st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    always_comb begin
        o_dat_next = '0;
        o_usr_next = 1'b0;
        if (cmd_reg.in_range && c_rd != 32'd0) begin
            o_usr_next          = 1'b1;
            o_dat_next[31:0]    = c_rd;
            o_dat_next[95:32]   = v_rd;
            o_dat_next[127:96]  = 32'(lo_rd);
            o_dat_next[159:128] = 32'(hi_rd);
            o_dat_next[191:160] = 32'(la_rd);
            o_dat_next[231:192] = 40'(mn_rd);
        end
        o_dat_next[242:232] = 11'(trk_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_CLEAR;
            clr_reg   <= '0;
            trk_reg   <= '0;
            o_val_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (st_reg == ST_CLEAR) clr_reg <= clr_reg + (AW+1)'(1);
            if (we_d && c_rd == 32'd0) trk_reg <= trk_reg + TW'(1);
            if (st_reg == ST_OUT && (!o_val_reg || m_tready))
                o_val_reg <= 1'b1;
            else if (m_tready)
                o_val_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ST_IDLE && q_valid) cmd_reg <= q_cmd;
        // after write-back, reread to present updated entry as a query
        if (we_d) cmd_reg.query <= 1'b1;
        if (st_reg == ST_CALC) neg_reg <= (p_fx < mn_rd);
        if (st_reg == ST_OUT && (!o_val_reg || m_tready)) begin
            o_dat_reg <= o_dat_next;
            o_usr_reg <= o_usr_next;
        end
    end
endmodule

// ===== src/per_symbol_price_stats_unit.sv =====
// Top level of the per-symbol price statistics unit.
// Depends on pss_pkg, pss_front and pss_back.
//
// channel | dir | tuser | tdata fields (lsb first)
// s_      | in  | op    | symbol_id, price, volume
// m_      | out | found | event_count, total_volume, min, max, last, mean, tracked
//
// A query passes the back end through its read and output states. An in-range
// record is written back and reread as a query; on a non-empty entry it first
// waits on the bit-serial mean divider. After reset the count store is cleared,
// one entry a cycle, all SYMBOLS entries; meanwhile only the two-entry front
// queue fills. A stalled result holds the back end once it reaches its output
// state with the next transaction; the queue then takes at most two more.
module per_symbol_price_stats_unit #(
    parameter int SYMBOLS    = 1024,
    parameter int PRICE_BITS = 32,
    parameter int FRAC_BITS  = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,  // symbol_id, price, volume, zero pad
    input  logic         s_tuser,  // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [247:0] m_tdata,  // event_count, total_volume, min_price,
                                   // max_price, last_price, mean_price,
                                   // tracked_symbols, zero pad
    output logic         m_tuser   // found
);
    logic          q_valid, q_ready, busy;
    pss_pkg::cmd_t q_cmd;

    pss_front #(.SYMBOLS(SYMBOLS), .PRICE_BITS(PRICE_BITS)) u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata(s_tdata[73:0]), .s_tuser,
        .q_valid, .q_ready, .q_cmd);

    pss_back #(.SYMBOLS(SYMBOLS), .PRICE_BITS(PRICE_BITS),
               .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .busy);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[31:0] != 32'd0)
        else $error("found with zero count");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> busy)
        else $error("result without back end activity");
endmodule
